// ----- design/rtc_nibble_register_bank_macros.svh -----
// ----------------------------------------------------------------------------
// RTC nibble register bank assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RTC_NIBBLE_REGISTER_BANK_MACROS_SVH
`define RTC_NIBBLE_REGISTER_BANK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNRB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rnrb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RNRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rnrb assertion failed");

`endif

// ----- design/rnrb_pkg.sv -----
// ----------------------------------------------------------------------------
// RTC nibble register bank package
// Operation codes, layout constants and the BCD digit split.
// ----------------------------------------------------------------------------
package rnrb_pkg;

	// Bus operations carried by the op field.
	typedef enum logic [1:0] {
		OP_ADDR  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_TIME  = 2'd3
	} op_t;

	// Register layout.
	localparam int CELLS_PER_BLOCK = 13;
	localparam logic [3:0] SELECT_REG = 4'd13;
	localparam int NIBBLE_W = 4;

	// Blocks 1 to 3 live in RAM, each block on a 16-entry boundary.
	localparam int RAM_BLOCKS = 3;
	localparam int RAM_DEPTH = RAM_BLOCKS * 16;
	localparam int RAM_AW = $clog2(RAM_DEPTH);

	// Two BCD digits of a byte value.
	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] units;
	} bcd_pair_t;

	// Split a byte into its units digit and its tens digit modulo ten.
	// Division by ten uses the reciprocal 205/2048, exact for all bytes.
	function automatic bcd_pair_t bcd_split(input logic [7:0] v);
		logic [15:0] p1;
		logic [4:0]  q1;
		logic [12:0] p2;
		logic [1:0]  q2;
		bcd_pair_t   r;
		p1 = 16'(v) * 16'd205;
		q1 = p1[15:11];
		p2 = 13'(q1) * 13'd205;
		q2 = p2[12:11];
		r.units = 4'(v - 8'(q1) * 8'd10);
		r.tens  = 4'(q1 - 5'(q2) * 5'd10);
		return r;
	endfunction

endpackage

// ----- design/rnrb_ram.sv -----
// ----------------------------------------------------------------------------
// RTC nibble register bank RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rnrb_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read in the same cycle as a write to that entry returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/rtc_nibble_register_bank.sv -----
// ----------------------------------------------------------------------------
// RTC nibble register bank
// Address latch, block select and four blocks of thirteen nibble cells.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_ready) carries a bus transaction:
// an address write, a data write, a data read or a calendar time update.
// Every input transaction produces exactly one output transaction
// (out_valid/out_ready) with read_data, zero unless the operation was a data
// read, and the dirty flag as it stands after that operation.
// out_valid rises when the transaction moves from stage 1 into the output
// register. One transaction is accepted per cycle unless the output stalls;
// the RAM that holds blocks 1 to 3 is read at acceptance and written when
// the transaction leaves stage 1, with a forwarding path between the two.
// Block 0 is held in flip-flops so that a time update loads all of its
// thirteen cells together at acceptance.
// Reset clears the address latch, block select, dirty flag and the per-cell
// valid bits, so every cell reads as zero until written; no clearing pass.
// When the receiver stalls, the output register holds its transaction, the
// stage before it fills, and then in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`include "rtc_nibble_register_bank_macros.svh"

module rtc_nibble_register_bank (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] data,
	input  logic [5:0] seconds,
	input  logic [5:0] minutes,
	input  logic [4:0] hours,
	input  logic [2:0] weekday,
	input  logic [4:0] day_of_month,
	input  logic [3:0] month,
	input  logic [7:0] years_since_1980,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       dirty
);

	// Architectural state.
	logic [3:0]                   reg_address_q;
	logic [1:0]                   block_select_q;
	logic [rnrb_pkg::NIBBLE_W-1:0] blk0_q [rnrb_pkg::CELLS_PER_BLOCK];
	logic [rnrb_pkg::RAM_DEPTH-1:0] ram_valid_q;
	logic                         dirty_q;

	// Stage 1: accepted transaction waiting for RAM read data.
	logic                          valid_s1;
	rnrb_pkg::op_t                 op_s1;
	logic [3:0]                    nib_s1;
	logic [1:0]                    blk_s1;
	logic                          use_ram_s1;
	logic [rnrb_pkg::RAM_AW-1:0]   addr_s1;
	logic [7:0]                    rd_direct_s1;
	logic                          byp_s1;
	logic [3:0]                    byp_data_s1;

	// Stage 2: output register.
	logic       out_valid_s2;
	logic [7:0] read_data_s2;
	logic       dirty_s2;

	// Decode of the incoming transaction against the current state.
	rnrb_pkg::op_t               op_in;
	logic [3:0]                  nib_in;
	logic                        in_accept;
	logic                        is_cell_in;
	logic                        use_ram_in;
	logic [rnrb_pkg::RAM_AW-1:0] addr_in;
	logic [1:0]                  blk_m1_in;
	logic [7:0]                  rd_direct_in;

	// Stage 1 datapath.
	logic                        s1_adv;
	logic [3:0]                  ram_rdata;
	logic [3:0]                  cell_s1;
	logic                        ram_we;
	logic                        dirty_nxt;
	logic [7:0]                  rd_s1;

	// BCD digits for a time update.
	rnrb_pkg::bcd_pair_t sec_bcd;
	rnrb_pkg::bcd_pair_t min_bcd;
	rnrb_pkg::bcd_pair_t hr_bcd;
	rnrb_pkg::bcd_pair_t dom_bcd;
	rnrb_pkg::bcd_pair_t mon_bcd;
	rnrb_pkg::bcd_pair_t yr_bcd;

	// Handshake: stage 1 moves on when the output register is free.
	assign s1_adv    = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_accept = in_valid && in_ready;

	// Input decode.
	assign op_in      = rnrb_pkg::op_t'(op);
	assign nib_in     = data[3:0];
	assign is_cell_in = reg_address_q < rnrb_pkg::SELECT_REG;
	assign use_ram_in = (op_in == rnrb_pkg::OP_WRITE || op_in == rnrb_pkg::OP_READ)
		&& is_cell_in && (block_select_q != 2'd0);
	assign blk_m1_in  = block_select_q - 2'd1;
	assign addr_in    = {blk_m1_in, reg_address_q};

	// Read values that do not come from the RAM.
	always_comb begin
		rd_direct_in = 8'h00;
		if (op_in == rnrb_pkg::OP_READ) begin
			if (reg_address_q == rnrb_pkg::SELECT_REG) begin
				rd_direct_in = {6'b111100, block_select_q};
			end else if (!is_cell_in) begin
				rd_direct_in = 8'hff;
			end else begin
				rd_direct_in = {4'hf, blk0_q[reg_address_q]};
			end
		end
	end

	// Digit split of the calendar fields.
	assign sec_bcd = rnrb_pkg::bcd_split(8'(seconds));
	assign min_bcd = rnrb_pkg::bcd_split(8'(minutes));
	assign hr_bcd  = rnrb_pkg::bcd_split(8'(hours));
	assign dom_bcd = rnrb_pkg::bcd_split(8'(day_of_month));
	assign mon_bcd = rnrb_pkg::bcd_split(8'(month));
	assign yr_bcd  = rnrb_pkg::bcd_split(years_since_1980);

	// Address latch, block select and block 0 cells update at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_address_q  <= 4'd0;
			block_select_q <= 2'd0;
			for (int i = 0; i < rnrb_pkg::CELLS_PER_BLOCK; i++) begin
				blk0_q[i] <= '0;
			end
		end else if (in_accept) begin
			case (op_in)
				rnrb_pkg::OP_ADDR: begin
					reg_address_q <= nib_in;
				end
				rnrb_pkg::OP_WRITE: begin
					if (reg_address_q == rnrb_pkg::SELECT_REG) begin
						block_select_q <= nib_in[1:0];
					end else if (is_cell_in && block_select_q == 2'd0) begin
						blk0_q[reg_address_q] <= nib_in;
					end
				end
				rnrb_pkg::OP_TIME: begin
					blk0_q[0]  <= sec_bcd.units;
					blk0_q[1]  <= sec_bcd.tens;
					blk0_q[2]  <= min_bcd.units;
					blk0_q[3]  <= min_bcd.tens;
					blk0_q[4]  <= hr_bcd.units;
					blk0_q[5]  <= hr_bcd.tens;
					blk0_q[6]  <= {1'b0, weekday};
					blk0_q[7]  <= dom_bcd.units;
					blk0_q[8]  <= dom_bcd.tens;
					blk0_q[9]  <= mon_bcd.units;
					blk0_q[10] <= mon_bcd.tens;
					blk0_q[11] <= yr_bcd.units;
					blk0_q[12] <= yr_bcd.tens;
				end
				default: begin
				end
			endcase
		end
	end

	// RAM for blocks 1 to 3, read at acceptance, written when stage 1 moves on.
	rnrb_ram #(
		.WIDTH(rnrb_pkg::NIBBLE_W),
		.DEPTH(rnrb_pkg::RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(nib_s1),
		.re   (in_accept),
		.raddr(addr_in),
		.rdata(ram_rdata)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload, with forwarding of a write to the entry being read.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1        <= op_in;
			nib_s1       <= nib_in;
			blk_s1       <= block_select_q;
			use_ram_s1   <= use_ram_in;
			addr_s1      <= addr_in;
			rd_direct_s1 <= rd_direct_in;
			byp_s1       <= ram_we && (addr_s1 == addr_in);
			byp_data_s1  <= nib_s1;
		end
	end

	// Current cell value: forwarded, stored, or zero if never written.
	always_comb begin
		if (byp_s1) begin
			cell_s1 = byp_data_s1;
		end else if (ram_valid_q[addr_s1]) begin
			cell_s1 = ram_rdata;
		end else begin
			cell_s1 = 4'h0;
		end
	end

	// A data write to blocks 1 to 3 stores only a changed nibble.
	assign ram_we    = s1_adv && (op_s1 == rnrb_pkg::OP_WRITE) && use_ram_s1
		&& (cell_s1 != nib_s1);
	assign dirty_nxt = dirty_q || (ram_we && blk_s1[1]);
	assign rd_s1     = (op_s1 == rnrb_pkg::OP_READ && use_ram_s1) ? {4'hf, cell_s1}
		: rd_direct_s1;

	// Valid bits and the dirty flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_valid_q <= '0;
			dirty_q     <= 1'b0;
		end else begin
			if (ram_we) begin
				ram_valid_q[addr_s1] <= 1'b1;
			end
			dirty_q <= dirty_nxt;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (!out_valid_s2 || out_ready) begin
			out_valid_s2 <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			read_data_s2 <= rd_s1;
			dirty_s2     <= dirty_nxt;
		end
	end

	assign out_valid = out_valid_s2;
	assign read_data = read_data_s2;
	assign dirty     = dirty_s2;

	// Checks on the pipeline and the stored state.
	`RNRB_ASSERT_NEXT(a_dirty_sticky, clk, arst_n, dirty_q, dirty_q)
	`RNRB_ASSERT_SAME(a_ram_we_blocks, clk, arst_n, ram_we, (blk_s1 != 2'd0) && valid_s1)
	`RNRB_ASSERT_SAME(a_stall_blocks_input, clk, arst_n, valid_s1 && !s1_adv, !in_ready)

endmodule
